>>> rtl/r2y420_pkg.sv
// ----------------------------------------------------------------------------
// r2y420_pkg
// Shared types and constants for the RGB to YUV 4:2:0 converter: register
// indexes, reset values, conversion coefficients and the divide-by-100 helper.
// ----------------------------------------------------------------------------
package r2y420_pkg;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 12;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SWAP         = 2'd2;

  // Register reset values.
  localparam logic [CFG_DATA_BITS-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_DATA_BITS-1:0] RST_FRAME_HEIGHT = 12'd480;
  localparam logic                     RST_SWAP         = 1'b1;

  // Output field widths.
  localparam int unsigned LUMA_IDX_BITS   = 22;
  localparam int unsigned CHROMA_IDX_BITS = 20;

  // Color conversion sums stay below 25600, so 15 bits hold them.
  localparam int unsigned SUM_BITS = 15;

  localparam logic [15:0] COEF_30     = 16'd30;
  localparam logic [15:0] COEF_59     = 16'd59;
  localparam logic [15:0] COEF_11     = 16'd11;
  localparam logic [15:0] COEF_17     = 16'd17;
  localparam logic [15:0] COEF_33     = 16'd33;
  localparam logic [15:0] COEF_50     = 16'd50;
  localparam logic [15:0] COEF_42     = 16'd42;
  localparam logic [15:0] COEF_8      = 16'd8;
  localparam logic [15:0] CHROMA_BIAS = 16'd12800;

  // Division by 100 as a multiply by ceil(2^22 / 100) and a shift. The
  // rounding error stays below 0.008 for any 15-bit dividend, so the
  // quotient is exact.
  localparam logic [15:0] DIV100_RECIP = 16'd41944;
  localparam int unsigned DIV100_SHIFT = 22;

  // Pipeline load strobes shared by the datapath modules.
  typedef struct packed {
    logic load_s1;
    logic load_s2;
    logic load_out;
  } pipe_ctl_t;

  function automatic logic [7:0] div100(input logic [SUM_BITS-1:0] x);
    logic [30:0] prod;
    prod = 31'(x) * 31'(DIV100_RECIP);
    return prod[DIV100_SHIFT+7:DIV100_SHIFT];
  endfunction

endpackage

>>> rtl/r2y420_cfg.sv
// ----------------------------------------------------------------------------
// r2y420_cfg
// Configuration registers. Frame sizes of zero or above the maximum are
// replaced by the maximum before they reach the scan counters.
// ----------------------------------------------------------------------------
module r2y420_cfg #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048,
  localparam int unsigned EW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned EH = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [r2y420_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [r2y420_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic [EW-1:0]                          eff_width,
  output logic [EH-1:0]                          eff_height,
  output logic                                   swap
);

  localparam int unsigned DW   = r2y420_pkg::CFG_DATA_BITS;
  localparam int unsigned CMPW = (EW > DW) ? EW : DW;
  localparam int unsigned CMPH = (EH > DW) ? EH : DW;

  logic [DW-1:0] frame_width;
  logic [DW-1:0] frame_height;
  logic          cfg_write;

  // Writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= r2y420_pkg::RST_FRAME_WIDTH;
      frame_height <= r2y420_pkg::RST_FRAME_HEIGHT;
      swap         <= r2y420_pkg::RST_SWAP;
    end else if (cfg_write) begin
      case (cfg_index)
        r2y420_pkg::CFG_IDX_FRAME_WIDTH:  frame_width  <= cfg_data;
        r2y420_pkg::CFG_IDX_FRAME_HEIGHT: frame_height <= cfg_data;
        r2y420_pkg::CFG_IDX_SWAP:         swap         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero or oversized values fall back to the maximum.
  always_comb begin
    if (frame_width == '0 || CMPW'(frame_width) > CMPW'(MAX_WIDTH)) begin
      eff_width = EW'(MAX_WIDTH);
    end else begin
      eff_width = EW'(frame_width);
    end
    if (frame_height == '0 || CMPH'(frame_height) > CMPH'(MAX_HEIGHT)) begin
      eff_height = EH'(MAX_HEIGHT);
    end else begin
      eff_height = EH'(frame_height);
    end
  end

endmodule

>>> rtl/r2y420_scan.sv
// ----------------------------------------------------------------------------
// r2y420_scan
// Raster position counters. Gives the column and row of the pixel at the
// input, its chroma and frame-end flags, and steps on every accepted pixel.
// ----------------------------------------------------------------------------
module r2y420_scan #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048,
  localparam int unsigned EW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned EH = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  r2y420_pkg::pipe_ctl_t ctl,
  input  logic [EW-1:0]         eff_width,
  input  logic [EH-1:0]         eff_height,
  output logic [CW-1:0]         column_count,
  output logic [RW-1:0]         row_count,
  output logic                  chroma_flag,
  output logic                  frame_flag
);

  logic row_last;
  logic last_row;

  // End of row and end of frame; counters beyond the limit also end them.
  always_comb begin
    row_last    = ((EW+1)'(column_count) + 1'b1) >= (EW+1)'(eff_width);
    last_row    = ((EH+1)'(row_count) + 1'b1) >= (EH+1)'(eff_height);
    frame_flag  = row_last && last_row;
    chroma_flag = column_count[0] && (row_count[0] || last_row);
  end

  // Position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (ctl.load_s1) begin
      if (frame_flag) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (row_last) begin
        column_count <= '0;
        row_count    <= row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

endmodule

>>> rtl/r2y420_index.sv
// ----------------------------------------------------------------------------
// r2y420_index
// Luma and chroma plane addresses. The row products are formed in the middle
// stage and the column offsets are added before the result register.
// ----------------------------------------------------------------------------
module r2y420_index #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048,
  localparam int unsigned EW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                                       clk,
  input  r2y420_pkg::pipe_ctl_t                      ctl,
  input  logic [EW-1:0]                              eff_width,
  input  logic [CW-1:0]                              column_count,
  input  logic [RW-1:0]                              row_count,
  input  logic                                       chroma_flag,
  input  logic                                       frame_flag,
  output logic [r2y420_pkg::LUMA_IDX_BITS-1:0]       luma_index,
  output logic [r2y420_pkg::CHROMA_IDX_BITS-1:0]     chroma_index,
  output logic                                       chroma_valid,
  output logic                                       frame_end
);

  localparam int unsigned MW = RW + EW;
  localparam int unsigned PW = (MW > r2y420_pkg::LUMA_IDX_BITS) ?
                               MW : r2y420_pkg::LUMA_IDX_BITS;

  logic [CW-1:0] col1;
  logic [RW-1:0] row1;
  logic [EW-1:0] width1;
  logic          cflag1;
  logic          fflag1;

  logic [MW-1:0] luma_prod2;
  logic [MW-1:0] chroma_prod2;
  logic [CW-1:0] col2;
  logic          cflag2;
  logic          fflag2;

  logic [PW-1:0] luma_sum;
  logic [PW-1:0] chroma_sum;

  // Input register: position of the accepted pixel.
  always_ff @(posedge clk) begin
    if (ctl.load_s1) begin
      col1   <= column_count;
      row1   <= row_count;
      width1 <= eff_width;
      cflag1 <= chroma_flag;
      fflag1 <= frame_flag;
    end
  end

  // Middle stage: row start addresses of both planes.
  always_ff @(posedge clk) begin
    if (ctl.load_s2) begin
      luma_prod2   <= MW'(row1) * MW'(width1);
      chroma_prod2 <= MW'(row1 >> 1) * MW'(width1 >> 1);
      col2         <= col1;
      cflag2       <= cflag1;
      fflag2       <= fflag1;
    end
  end

  // Column offsets, truncated to the output field widths.
  always_comb begin
    luma_sum   = PW'(luma_prod2) + PW'(col2);
    chroma_sum = PW'(chroma_prod2) + PW'(col2 >> 1);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      luma_index   <= luma_sum[r2y420_pkg::LUMA_IDX_BITS-1:0];
      chroma_index <= chroma_sum[r2y420_pkg::CHROMA_IDX_BITS-1:0];
      chroma_valid <= cflag2;
      frame_end    <= fflag2;
    end
  end

endmodule

>>> rtl/r2y420_color.sv
// ----------------------------------------------------------------------------
// r2y420_color
// Color space conversion. Channel bytes are ordered into R, G and B, the
// weighted sums are formed in the middle stage, and the divide by 100 is
// done by a reciprocal multiply before the result register.
// ----------------------------------------------------------------------------
module r2y420_color (
  input  logic                  clk,
  input  r2y420_pkg::pipe_ctl_t ctl,
  input  logic                  swap,
  input  logic [7:0]            chan_first,
  input  logic [7:0]            chan_middle,
  input  logic [7:0]            chan_third,
  output logic [7:0]            luma_value,
  output logic [7:0]            cb_value,
  output logic [7:0]            cr_value
);

  localparam int unsigned SW = r2y420_pkg::SUM_BITS;

  logic [7:0]    red1;
  logic [7:0]    green1;
  logic [7:0]    blue1;
  logic [15:0]   red_w;
  logic [15:0]   green_w;
  logic [15:0]   blue_w;
  logic [SW-1:0] y_sum_next;
  logic [SW-1:0] u_sum_next;
  logic [SW-1:0] v_sum_next;
  logic [SW-1:0] y_sum;
  logic [SW-1:0] u_sum;
  logic [SW-1:0] v_sum;

  // Input register with the red/blue exchange applied.
  always_ff @(posedge clk) begin
    if (ctl.load_s1) begin
      red1   <= swap ? chan_third : chan_first;
      green1 <= chan_middle;
      blue1  <= swap ? chan_first : chan_third;
    end
  end

  // Weighted sums. Both chroma sums stay positive thanks to the bias.
  always_comb begin
    red_w      = 16'(red1);
    green_w    = 16'(green1);
    blue_w     = 16'(blue1);
    y_sum_next = SW'(red_w * r2y420_pkg::COEF_30 + green_w * r2y420_pkg::COEF_59 +
                     blue_w * r2y420_pkg::COEF_11);
    u_sum_next = SW'(r2y420_pkg::CHROMA_BIAS + blue_w * r2y420_pkg::COEF_50 -
                     (red_w * r2y420_pkg::COEF_17 + green_w * r2y420_pkg::COEF_33));
    v_sum_next = SW'(r2y420_pkg::CHROMA_BIAS + red_w * r2y420_pkg::COEF_50 -
                     (green_w * r2y420_pkg::COEF_42 + blue_w * r2y420_pkg::COEF_8));
  end

  always_ff @(posedge clk) begin
    if (ctl.load_s2) begin
      y_sum <= y_sum_next;
      u_sum <= u_sum_next;
      v_sum <= v_sum_next;
    end
  end

  // Quotients into the result register.
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      luma_value <= r2y420_pkg::div100(y_sum);
      cb_value   <= r2y420_pkg::div100(u_sum);
      cr_value   <= r2y420_pkg::div100(v_sum);
    end
  end

endmodule

>>> rtl/rgb_to_yuv420_converter_top.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_top
// RGB to YUV 4:2:0 pixel converter, one pixel per clock unless res_stall holds.
// ----------------------------------------------------------------------------
// Pixels enter on the pix channel in raster order (pix_valid / pix_stall) as
// three channel bytes. Each accepted pixel gives one transaction on the res
// channel (res_valid / res_stall) with its luma address and Y, its chroma
// block address with U and V, a chroma_valid flag on the pixel whose chroma
// is kept for its 2x2 block, and frame_end on the last pixel of a frame.
// The cfg channel (cfg_valid / cfg_ready, always ready) writes frame width,
// frame height and the red/blue swap; write it only while the block is idle.
// A pixel passes the input and middle registers into the result register,
// where res_valid rises with its result. The pipeline is an input register,
// a middle register after the multipliers and the result register, so a new
// pixel is taken every cycle until a receiver stall fills the pipeline.
// When the receiver stalls, the result holds and the two earlier stages keep
// filling; pix_stall rises only once all three stages hold a pixel.
// Synchronous reset empties the pipeline, returns the raster counters to the
// first pixel of a frame and loads 640x480 with the swap set.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_top #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [r2y420_pkg::CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [r2y420_pkg::CFG_DATA_BITS-1:0]       cfg_data,
  input  logic                                       pix_valid,
  output logic                                       pix_stall,
  input  logic [7:0]                                 chan_first,
  input  logic [7:0]                                 chan_middle,
  input  logic [7:0]                                 chan_third,
  output logic                                       res_valid,
  input  logic                                       res_stall,
  output logic [r2y420_pkg::LUMA_IDX_BITS-1:0]       luma_index,
  output logic [7:0]                                 luma_value,
  output logic                                       chroma_valid,
  output logic [r2y420_pkg::CHROMA_IDX_BITS-1:0]     chroma_index,
  output logic [7:0]                                 cb_value,
  output logic [7:0]                                 cr_value,
  output logic                                       frame_end
);

  localparam int unsigned EW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EH = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;

  logic                  s1_valid;
  logic                  s2_valid;
  logic                  out_en;
  logic                  s2_en;
  logic                  s1_en;
  r2y420_pkg::pipe_ctl_t ctl;

  logic [EW-1:0] eff_width;
  logic [EH-1:0] eff_height;
  logic          swap;
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic          chroma_flag;
  logic          frame_flag;

  // Stage enables: a stage may load when it is empty or is being drained.
  always_comb begin
    out_en       = !res_valid || !res_stall;
    s2_en        = !s2_valid || out_en;
    s1_en        = !s1_valid || s2_en;
    pix_stall    = !s1_en;
    ctl.load_s1  = pix_valid && s1_en;
    ctl.load_s2  = s1_valid && s2_en;
    ctl.load_out = s2_valid && out_en;
  end

  // Stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1_valid  <= ctl.load_s1 || (s1_valid && !s2_en);
      s2_valid  <= ctl.load_s2 || (s2_valid && !out_en);
      res_valid <= ctl.load_out || (res_valid && res_stall);
    end
  end

  r2y420_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .swap       (swap)
  );

  r2y420_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .eff_width    (eff_width),
    .eff_height   (eff_height),
    .column_count (column_count),
    .row_count    (row_count),
    .chroma_flag  (chroma_flag),
    .frame_flag   (frame_flag)
  );

  r2y420_index #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_index (
    .clk          (clk),
    .ctl          (ctl),
    .eff_width    (eff_width),
    .column_count (column_count),
    .row_count    (row_count),
    .chroma_flag  (chroma_flag),
    .frame_flag   (frame_flag),
    .luma_index   (luma_index),
    .chroma_index (chroma_index),
    .chroma_valid (chroma_valid),
    .frame_end    (frame_end)
  );

  r2y420_color u_color (
    .clk         (clk),
    .ctl         (ctl),
    .swap        (swap),
    .chan_first  (chan_first),
    .chan_middle (chan_middle),
    .chan_third  (chan_third),
    .luma_value  (luma_value),
    .cb_value    (cb_value),
    .cr_value    (cr_value)
  );

  // The input is held back only when every stage is full and the result waits.
  assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (s1_valid && s2_valid && res_valid && res_stall))
    else $error("pix_stall raised while the pipeline has room");

  // A pixel in the middle stage reaches the result register unless it is held.
  assert property (@(posedge clk) disable iff (rst)
    (s2_valid && out_en) |=> res_valid)
    else $error("middle stage drained without producing a result");

  // Reset leaves the pipeline empty.
  assert property (@(posedge clk)
    rst |=> (!s1_valid && !s2_valid && !res_valid))
    else $error("pipeline not empty after reset");

endmodule

>>> dv/rgb_to_yuv420_checker.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_checker
// Watches the configuration, pixel and result channels of the RGB to YUV
// 4:2:0 converter. It keeps its own copy of the registers and the raster
// position, predicts the result of every accepted pixel and compares each
// accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_checker #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic [r2y420_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [r2y420_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                   pix_valid,
  input  logic                                   pix_stall,
  input  logic [7:0]                             chan_first,
  input  logic [7:0]                             chan_middle,
  input  logic [7:0]                             chan_third,
  input  logic                                   res_valid,
  input  logic                                   res_stall,
  input  logic [r2y420_pkg::LUMA_IDX_BITS-1:0]   luma_index,
  input  logic [7:0]                             luma_value,
  input  logic                                   chroma_valid,
  input  logic [r2y420_pkg::CHROMA_IDX_BITS-1:0] chroma_index,
  input  logic [7:0]                             cb_value,
  input  logic [7:0]                             cr_value,
  input  logic                                   frame_end,
  output int                                     mismatch_count,
  output int                                     results_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LW  = r2y420_pkg::LUMA_IDX_BITS;
  localparam int unsigned CIW = r2y420_pkg::CHROMA_IDX_BITS;

  typedef struct packed {
    logic [LW-1:0]  luma_index;
    logic [7:0]     luma_value;
    logic           chroma_valid;
    logic [CIW-1:0] chroma_index;
    logic [7:0]     cb_value;
    logic [7:0]     cr_value;
    logic           frame_end;
  } pixel_out_t;

  // Register copy and raster position of the next pixel.
  logic [r2y420_pkg::CFG_DATA_BITS-1:0] width_cfg;
  logic [r2y420_pkg::CFG_DATA_BITS-1:0] height_cfg;
  logic                                 swap_cfg;
  int unsigned                          col_pos;
  int unsigned                          row_pos;

  pixel_out_t pending_pixels[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want, input int unsigned at_idx);
    if (got !== want) begin
      report_mismatch($sformatf("%s of pixel %0d: got 0x%0h, expected 0x%0h",
                                field, at_idx, got, want));
    end
  endtask

  // Converts one pixel and steps the raster position, including the row and
  // frame wrap, exactly as the block does.
  function automatic pixel_out_t convert_pixel(input logic [7:0] c_first,
                                               input logic [7:0] c_mid,
                                               input logic [7:0] c_third);
    int          red;
    int          green;
    int          blue;
    int          y_val;
    int          u_val;
    int          v_val;
    int unsigned w;
    int unsigned h;
    int unsigned lidx;
    int unsigned cidx;
    logic        row_last;
    logic        last_row;
    pixel_out_t  px;
    // Zero and oversized registers saturate to the maximum frame size.
    w = (width_cfg == '0 || int'(width_cfg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_cfg);
    h = (height_cfg == '0 || int'(height_cfg) > MAX_HEIGHT) ? MAX_HEIGHT
                                                             : int'(height_cfg);
    red   = swap_cfg ? int'(c_third) : int'(c_first);
    blue  = swap_cfg ? int'(c_first) : int'(c_third);
    green = int'(c_mid);
    y_val = (30 * red + 59 * green + 11 * blue) / 100;
    u_val = (-17 * red - 33 * green + 50 * blue + 12800) / 100;
    v_val = (50 * red - 42 * green - 8 * blue + 12800) / 100;
    // A counter at or past the last column or row closes the row or frame.
    row_last = (col_pos >= w - 1);
    last_row = (row_pos >= h - 1);
    lidx = row_pos * w + col_pos;
    cidx = (row_pos >> 1) * (w >> 1) + (col_pos >> 1);
    px.luma_index   = lidx[LW-1:0];
    px.luma_value   = 8'(y_val);
    px.chroma_valid = col_pos[0] && (row_pos[0] || last_row);
    px.chroma_index = cidx[CIW-1:0];
    px.cb_value     = 8'(u_val);
    px.cr_value     = 8'(v_val);
    px.frame_end    = row_last && last_row;
    if (row_last && last_row) begin
      col_pos = 0;
      row_pos = 0;
    end else if (row_last) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return px;
  endfunction

  // All channels are sampled at the rising edge; the stimulus changes at the
  // falling edge, so every value seen here is settled.
  always @(posedge clk) begin
    pixel_out_t want;
    if (rst) begin
      width_cfg  = r2y420_pkg::RST_FRAME_WIDTH;
      height_cfg = r2y420_pkg::RST_FRAME_HEIGHT;
      swap_cfg   = r2y420_pkg::RST_SWAP;
      col_pos    = 0;
      row_pos    = 0;
      pending_pixels.delete();
      mismatch_count = 0;
    end else begin
      // Register write transaction.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          r2y420_pkg::CFG_IDX_FRAME_WIDTH:  width_cfg  = cfg_data;
          r2y420_pkg::CFG_IDX_FRAME_HEIGHT: height_cfg = cfg_data;
          r2y420_pkg::CFG_IDX_SWAP:         swap_cfg   = cfg_data[0];
          default: ;
        endcase
      end
      // Pixel transaction: predict its result.
      if (pix_valid && !pix_stall) begin
        pending_pixels.push_back(convert_pixel(chan_first, chan_middle, chan_third));
      end
      // Result transaction: compare with the oldest prediction.
      if (res_valid && !res_stall) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("result transaction with no pixel pending, luma_index %0d",
                                    luma_index));
        end else begin
          want = pending_pixels.pop_front();
          check_field("luma_index", 32'(luma_index), 32'(want.luma_index),
                      32'(want.luma_index));
          check_field("luma_value", 32'(luma_value), 32'(want.luma_value),
                      32'(want.luma_index));
          check_field("chroma_valid", 32'(chroma_valid), 32'(want.chroma_valid),
                      32'(want.luma_index));
          check_field("chroma_index", 32'(chroma_index), 32'(want.chroma_index),
                      32'(want.luma_index));
          check_field("cb_value", 32'(cb_value), 32'(want.cb_value),
                      32'(want.luma_index));
          check_field("cr_value", 32'(cr_value), 32'(want.cr_value),
                      32'(want.luma_index));
          check_field("frame_end", 32'(frame_end), 32'(want.frame_end),
                      32'(want.luma_index));
        end
      end
    end
    results_outstanding = pending_pixels.size();
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Top level for the RGB to YUV 4:2:0 converter. It drives pixels and
// register writes, stalls the result channel, and gives the verdict from the
// mismatch count of the checker that sits beside the block.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_WIDTH    = 2048;
  localparam int unsigned MAX_HEIGHT   = 2048;
  localparam int          RANDOM_ITEMS = 550;
  localparam int          HOLD_CYCLES  = 64;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          CIB          = r2y420_pkg::CFG_IDX_BITS;
  localparam int          CDW          = r2y420_pkg::CFG_DATA_BITS;
  // Index that maps to no register; a write to it must change nothing.
  localparam logic [CIB-1:0] CFG_IDX_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst;

  logic                                   cfg_valid;
  logic                                   cfg_ready;
  logic [CIB-1:0]                         cfg_index;
  logic [CDW-1:0]                         cfg_data;
  logic                                   pix_valid;
  logic                                   pix_stall;
  logic [7:0]                             chan_first;
  logic [7:0]                             chan_middle;
  logic [7:0]                             chan_third;
  logic                                   res_valid;
  logic                                   res_stall = 1'b0;
  logic [r2y420_pkg::LUMA_IDX_BITS-1:0]   luma_index;
  logic [7:0]                             luma_value;
  logic                                   chroma_valid;
  logic [r2y420_pkg::CHROMA_IDX_BITS-1:0] chroma_index;
  logic [7:0]                             cb_value;
  logic [7:0]                             cr_value;
  logic                                   frame_end;

  int mismatch_count;
  int results_outstanding;

  // Idle rates in percent, and the long receiver hold-off request.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  rgb_to_yuv420_converter_top #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .chan_first   (chan_first),
    .chan_middle  (chan_middle),
    .chan_third   (chan_third),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .luma_index   (luma_index),
    .luma_value   (luma_value),
    .chroma_valid (chroma_valid),
    .chroma_index (chroma_index),
    .cb_value     (cb_value),
    .cr_value     (cr_value),
    .frame_end    (frame_end)
  );

  rgb_to_yuv420_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .pix_valid           (pix_valid),
    .pix_stall           (pix_stall),
    .chan_first          (chan_first),
    .chan_middle         (chan_middle),
    .chan_third          (chan_third),
    .res_valid           (res_valid),
    .res_stall           (res_stall),
    .luma_index          (luma_index),
    .luma_value          (luma_value),
    .chroma_valid        (chroma_valid),
    .chroma_index        (chroma_index),
    .cb_value            (cb_value),
    .cr_value            (cr_value),
    .frame_end           (frame_end),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result channel stall: random at the current rate, or a long hold-off
  // whenever a new one is requested.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly small frames, even in width, so that frames complete often; now and
  // then a zero, oversized, maximum or odd setting.
  function automatic logic [CDW-1:0] pick_size(input bit is_width);
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CDW'($urandom_range(2049, 4095));
      2:       return CDW'(2048);
      3:       return is_width ? CDW'(2 * $urandom_range(1, 7) + 1)
                               : CDW'(1);
      default: return is_width ? CDW'(2 * $urandom_range(1, 8))
                               : CDW'($urandom_range(1, 6));
    endcase
  endfunction

  // Offers one pixel after a random gap and holds it until the transaction.
  // Starts and ends at a falling edge.
  task automatic send_pixel(input logic [7:0] c_first, input logic [7:0] c_mid,
                            input logic [7:0] c_third);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid   <= 1'b1;
    chan_first  <= c_first;
    chan_middle <= c_mid;
    chan_third  <= c_third;
    do @(posedge clk); while (pix_stall);
    @(negedge clk);
  endtask

  // Stops offering pixels and waits until every result has come back.
  task automatic drain();
    pix_valid <= 1'b0;
    while (results_outstanding != 0) @(negedge clk);
  endtask

  // One register write transaction; the caller lowers cfg_valid afterwards.
  task automatic write_reg(input logic [CIB-1:0] idx,
                           input logic [CDW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(input logic [CDW-1:0] width,
                           input logic [CDW-1:0] height,
                           input logic [CDW-1:0] swap_word);
    drain();
    write_reg(r2y420_pkg::CFG_IDX_FRAME_WIDTH, width);
    write_reg(r2y420_pkg::CFG_IDX_FRAME_HEIGHT, height);
    write_reg(r2y420_pkg::CFG_IDX_SWAP, swap_word);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int random_sent;
    int seg_len;
    int phase;
    int last_phase;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    pix_valid   = 1'b0;
    chan_first  = '0;
    chan_middle = '0;
    chan_third  = '0;
    random_sent = 0;
    last_phase  = -1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    send_idle_pct <= 14;
    recv_idle_pct <= 48;

    // Reset settings: 640x480 with red and blue swapped.
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);

    // A write to the unused index must leave every register alone.
    drain();
    write_reg(CFG_IDX_SPARE, 12'hFFF);
    cfg_valid <= 1'b0;
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h80, 8'h40, 8'h20);

    // A 2x1 frame, no swap. The kept column count is past the new last
    // column, so the first pixel closes the frame.
    configure(12'd2, 12'd1, 12'd0);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h00);

    // Odd width: rows end on an even column.
    configure(12'd3, 12'd2, 12'd1);
    send_pixel(8'h12, 8'hFF, 8'h34);
    send_pixel(8'hFF, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);
    send_pixel(8'hFF, 8'hFF, 8'hFF);

    // Zero and oversized sizes saturate; the swap takes bit 0 only.
    configure(12'd0, 12'd0, 12'hFFE);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'h01, 8'hFE, 8'h7F);
    send_pixel(8'h00, 8'h00, 8'h00);
    configure(12'hFFF, 12'hFFF, 12'h001);
    send_pixel(8'hFF, 8'h80, 8'h01);
    send_pixel(8'h00, 8'hFF, 8'hFF);

    // Odd height: the final row supplies its own chroma.
    configure(12'd4, 12'd3, 12'd1);
    send_pixel(8'h10, 8'h20, 8'h30);
    send_pixel(8'hF0, 8'hE0, 8'hD0);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'hFF);

    // Random segments, each under a fresh setting. The idle rates change by
    // phase, and each phase opens with a long receiver hold-off while pixels
    // keep coming.
    while (random_sent < RANDOM_ITEMS) begin
      phase = random_sent * 3 / RANDOM_ITEMS;
      case (phase)
        0: begin
          send_idle_pct <= 14;
          recv_idle_pct <= 48;
        end
        1: begin
          send_idle_pct <= 48;
          recv_idle_pct <= 14;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      configure(pick_size(1'b1), pick_size(1'b0), CDW'($urandom));
      if (phase != last_phase) begin
        hold_req   <= hold_req + 1;
        last_phase = phase;
      end
      seg_len = $urandom_range(12, 40);
      repeat (seg_len) begin
        send_pixel(rand_byte(), rand_byte(), rand_byte());
        random_sent++;
      end
    end

    // Let the pipeline empty, then give stray results time to show up.
    drain();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/r2y420_pkg.sv
rtl/r2y420_cfg.sv
rtl/r2y420_scan.sv
rtl/r2y420_index.sv
rtl/r2y420_color.sv
rtl/rgb_to_yuv420_converter_top.sv
dv/rgb_to_yuv420_checker.sv
dv/testbench.sv
